// ----- rtl/bbr_pkg.sv -----
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants for the 1bpp blit raster-op datapath
// Register map, combine mode codes, geometry widths and the transfer structs.
// ----------------------------------------------------------------------------
package bbr_pkg;

   localparam int ROW_W = 12;
   localparam int CNT_W = 10;
   localparam logic [ROW_W-1:0] MAX_ROW_PIXELS = 12'd4095;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_DEST_OFF = 2'd0;
   localparam logic [1:0] REG_SRC_OFF  = 2'd1;
   localparam logic [1:0] REG_ROW_W    = 2'd2;
   localparam logic [1:0] REG_MODE     = 2'd3;

   // combine modes
   localparam logic [2:0] MODE_COPY   = 3'd0;
   localparam logic [2:0] MODE_OR     = 3'd1;
   localparam logic [2:0] MODE_AND    = 3'd2;
   localparam logic [2:0] MODE_ANDNOT = 3'd3;
   localparam logic [2:0] MODE_XOR    = 3'd4;

   typedef struct packed {
      logic [2:0]       dest_bit_offset;
      logic [2:0]       src_bit_offset;
      logic [ROW_W-1:0] row_width;
      logic [2:0]       combine_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0] mask;
      logic       last;
   } mask_info_type;

   // pixel 0 is the MSB: keep pixels from position pos on
   function automatic logic [7:0] lead_mask(input logic [2:0] pos);
      lead_mask = 8'hFF >> pos;
   endfunction

endpackage

// ----- rtl/bbr_csr.sv -----
// ----------------------------------------------------------------------------
// bbr_csr: configuration registers
// APB-style write/read of the offset, row width and combine mode registers.
// ----------------------------------------------------------------------------
module bbr_csr import bbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_DEST_OFF: cfg_in.dest_bit_offset = csr_pwdata[2:0];
            REG_SRC_OFF:  cfg_in.src_bit_offset  = csr_pwdata[2:0];
            REG_ROW_W:    cfg_in.row_width       = csr_pwdata[ROW_W-1:0];
            REG_MODE:     cfg_in.combine_mode    = csr_pwdata[2:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_bit_offset <= 3'd0;
         cfg_ff.src_bit_offset  <= 3'd0;
         cfg_ff.row_width       <= ROW_W'(1);
         cfg_ff.combine_mode    <= MODE_COPY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEST_OFF: csr_prdata = {29'd0, cfg_ff.dest_bit_offset};
         REG_SRC_OFF:  csr_prdata = {29'd0, cfg_ff.src_bit_offset};
         REG_ROW_W:    csr_prdata = {{(32-ROW_W){1'b0}}, cfg_ff.row_width};
         REG_MODE:     csr_prdata = {29'd0, cfg_ff.combine_mode};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bbr_mask.sv -----
// ----------------------------------------------------------------------------
// bbr_mask: row byte counter and pixel mask
// Tracks the byte position within the row and builds the leading, whole or
// trailing mask plus the end-of-row flag for the transaction being accepted.
// ----------------------------------------------------------------------------
module bbr_mask import bbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          advance,
   output mask_info_type info
);

   logic [CNT_W-1:0] byte_in_row_ff, byte_in_row_in;
   logic [ROW_W-1:0] width;
   logic [ROW_W:0]   pix_end;
   logic [ROW_W+1:0] pix_round;
   logic [CNT_W-1:0] nbytes, last_idx;
   logic [2:0]       tail_pos;
   logic             last;
   logic [7:0]       mask;

   always_comb begin
      width     = (cfg.row_width > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : cfg.row_width;
      pix_end   = {1'b0, width} + (ROW_W+1)'(cfg.dest_bit_offset);
      pix_round = {1'b0, pix_end} + (ROW_W+2)'(7);
      nbytes    = pix_round[ROW_W:3];
      last_idx  = (nbytes == '0) ? '0 : nbytes - CNT_W'(1);
      last      = (byte_in_row_ff >= last_idx);
      tail_pos  = pix_end[2:0];

      if (width == '0) begin
         mask = 8'h00;
      end else begin
         mask = (byte_in_row_ff == '0) ? lead_mask(cfg.dest_bit_offset) : 8'hFF;
         // trailing byte keeps only pixels left of the row end
         if (last && tail_pos != 3'd0) begin
            mask = mask & ~lead_mask(tail_pos);
         end
      end
   end

   assign byte_in_row_in = last ? '0 : byte_in_row_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= '0;
      end else if (advance) begin
         byte_in_row_ff <= byte_in_row_in;
      end
   end

   assign info.mask = mask;
   assign info.last = last;

endmodule

// ----- rtl/bbr_rop.sv -----
// ----------------------------------------------------------------------------
// bbr_rop: funnel shift and masked raster operation
// Aligns the source pair to the destination and merges it into the old byte.
// ----------------------------------------------------------------------------
module bbr_rop import bbr_pkg::*; (
   input  cfg_type    cfg,
   input  logic [7:0] src_first,
   input  logic [7:0] src_next,
   input  logic [7:0] dst_old,
   input  logic [7:0] mask,
   output logic [7:0] dst_new
);

   logic [2:0]  shift;
   logic [15:0] pair;
   logic [7:0]  src_al;

   always_comb begin
      shift  = cfg.src_bit_offset - cfg.dest_bit_offset;
      pair   = {src_first, src_next} << shift;
      src_al = pair[15:8];

      case (cfg.combine_mode)
         MODE_COPY:   dst_new = (src_al & mask) | (dst_old & ~mask);
         MODE_OR:     dst_new = dst_old | (src_al & mask);
         MODE_AND:    dst_new = dst_old & (src_al | ~mask);
         MODE_ANDNOT: dst_new = dst_old & ~(src_al & mask);
         MODE_XOR:    dst_new = dst_old ^ (src_al & mask);
         default:     dst_new = dst_old;
      endcase
   end

endmodule

// ----- rtl/packed_bit_blit_rop.sv -----
// ----------------------------------------------------------------------------
// packed_bit_blit_rop: 1bpp blitter byte datapath
// Funnel-shifts source bytes onto the destination grid and merges them into
// the destination byte under the row mask with the selected raster op.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/stall    | src_byte_first, src_byte_next,
//            |           |                    | dst_byte_old
//   rsp      | out       | rsp_valid/stall    | dst_byte_new, row_end
//   csr      | in        | APB psel/penable   | offsets, row width, mode
//
// One transaction per cycle sustained while rsp_stall is low; results pass
// through the input register and then the result register around the
// shift/merge logic. The row counter and mask are taken at acceptance, so
// a full pipe keeps its ordering across stalls. rsp_stall backs up into
// req_stall only once both registers are occupied. Reset is synchronous:
// counter, valids and config registers are reset; data registers are not.
// ----------------------------------------------------------------------------
module packed_bit_blit_rop import bbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_byte_first,
   input  logic [7:0]  req_src_byte_next,
   input  logic [7:0]  req_dst_byte_old,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_dst_byte_new,
   output logic        rsp_row_end,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg;
   mask_info_type info;

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_first_ff, s1_next_ff, s1_old_ff;
   mask_info_type s1_info_ff;

   logic          s2_valid_ff, s2_valid_in;
   logic [7:0]    s2_dst_ff;
   logic          s2_last_ff;

   logic          s2_load, s1_load, req_take;
   logic [7:0]    dst_new;

   bbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbr_mask u_mask (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (req_take),
      .info    (info)
   );

   bbr_rop u_rop (
      .cfg       (cfg),
      .src_first (s1_first_ff),
      .src_next  (s1_next_ff),
      .dst_old   (s1_old_ff),
      .mask      (s1_info_ff.mask),
      .dst_new   (dst_new)
   );

   // result register takes a new transaction when empty or being drained
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;
   assign req_take  = req_valid && s1_load;

   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_ff <= req_src_byte_first;
         s1_next_ff  <= req_src_byte_next;
         s1_old_ff   <= req_dst_byte_old;
         s1_info_ff  <= info;
      end
      if (s2_load && s1_valid_ff) begin
         s2_dst_ff  <= dst_new;
         s2_last_ff <= s1_info_ff.last;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_dst_byte_new = s2_dst_ff;
   assign rsp_row_end      = s2_last_ff;

`ifndef SYNTHESIS
   // a full pipe under output stall must push back on the input
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted while both pipeline registers are held");

   // no back-pressure while the input register is free
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");

   // a held input register keeps its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff && $stable(s1_old_ff)
         && $stable(s1_info_ff))
      else $error("input register changed while held");
`endif

endmodule

// ----- sim/blit_rop_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blit_rop_checker: scoreboard for the 1bpp blit raster-op datapath
// Follows register writes on the csr port, predicts the merged destination
// byte and row end flag for every accepted req transaction, and compares
// each accepted rsp transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module blit_rop_checker import bbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_src_byte_first,
   input  logic [7:0]  req_src_byte_next,
   input  logic [7:0]  req_dst_byte_old,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_dst_byte_new,
   input  logic        rsp_row_end,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,

   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] dst_byte_new;
      logic       row_end;
   } blit_byte_type;

   logic [2:0]       dst_off;
   logic [2:0]       src_off;
   logic [ROW_W-1:0] row_px;
   logic [2:0]       rop_mode;
   logic [CNT_W-1:0] byte_pos;

   blit_byte_type expected_bytes[$];
   int            mismatches = 0;
   int            pending_cnt = 0;

   assign fail_count  = mismatches;
   assign outstanding = pending_cnt;

   function automatic blit_byte_type rop_byte(input logic [7:0] first, input logic [7:0] next,
                                              input logic [7:0] old);
      logic [ROW_W-1:0] w;
      logic [2:0]       sh;
      logic [15:0]      pair;
      logic [7:0]       shifted;
      logic [7:0]       msk;
      logic [12:0]      span;
      logic [CNT_W-1:0] nbytes;
      logic [2:0]       tail;
      blit_byte_type    r;
      w = (row_px > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : row_px;
      // source lands on the destination grid: shift by (src - dst) mod 8
      sh      = src_off - dst_off;
      pair    = {first, next} << sh;
      shifted = pair[15:8];
      span    = 13'(dst_off) + 13'(w) + 13'd7;
      nbytes  = CNT_W'(span >> 3);
      if (nbytes == 0) begin
         nbytes = 1;
      end
      // a counter beyond the row (after a mid-row rewrite) closes the row
      r.row_end = (byte_pos >= nbytes - 1'b1);
      if (w == 0) begin
         msk = 8'h00;
      end else begin
         msk  = (byte_pos == 0) ? (8'hFF >> dst_off) : 8'hFF;
         tail = dst_off + w[2:0];
         if (r.row_end && tail != 0) begin
            msk = msk & ~(8'hFF >> tail);
         end
      end
      case (rop_mode)
         MODE_COPY:   r.dst_byte_new = (shifted & msk) | (old & ~msk);
         MODE_OR:     r.dst_byte_new = old | (shifted & msk);
         MODE_AND:    r.dst_byte_new = old & (shifted | ~msk);
         MODE_ANDNOT: r.dst_byte_new = old & ~(shifted & msk);
         MODE_XOR:    r.dst_byte_new = old ^ (shifted & msk);
         default:     r.dst_byte_new = old;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      blit_byte_type want;
      if (reset) begin
         dst_off  = 3'd0;
         src_off  = 3'd0;
         row_px   = ROW_W'(1);
         rop_mode = MODE_COPY;
         byte_pos = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected rsp transaction: dst_byte_new %02h row_end %0d",
                      rsp_dst_byte_new, rsp_row_end);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_dst_byte_new !== want.dst_byte_new) begin
                  $error("dst_byte_new: expected %02h, actual %02h",
                         want.dst_byte_new, rsp_dst_byte_new);
                  mismatches++;
               end
               if (rsp_row_end !== want.row_end) begin
                  $error("row_end: expected %0d, actual %0d", want.row_end, rsp_row_end);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = rop_byte(req_src_byte_first, req_src_byte_next, req_dst_byte_old);
            expected_bytes.push_back(want);
            byte_pos = want.row_end ? '0 : byte_pos + 1'b1;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_DEST_OFF: dst_off  = csr_pwdata[2:0];
               REG_SRC_OFF:  src_off  = csr_pwdata[2:0];
               REG_ROW_W:    row_px   = csr_pwdata[ROW_W-1:0];
               REG_MODE:     rop_mode = csr_pwdata[2:0];
               default: ;
            endcase
         end
      end
      pending_cnt = expected_bytes.size();
   end

endmodule

// ----- sim/packed_bit_blit_rop_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_bit_blit_rop_tb: testbench top for the 1bpp blit raster-op datapath
// Programs geometry and combine mode over the csr port, streams source and
// destination bytes in bursts against a stalling receiver, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module packed_bit_blit_rop_tb;
   import bbr_pkg::*;

   localparam int NUM_ITEMS  = 800;
   localparam int IDLE_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_src_byte_first;
   logic [7:0]  req_src_byte_next;
   logic [7:0]  req_dst_byte_old;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_dst_byte_new;
   logic        rsp_row_end;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int outstanding;
   int burst_left;
   int gap_left;
   int idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   packed_bit_blit_rop dut (.*);

   blit_rop_checker checker_i (.*);

   // hang detection: no transaction on any port for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver backpressure: stretches of no stall, random stall, periodic stall
   initial begin
      int style, stretch, pct, on_len, off_len;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         pct     = $urandom_range(10, 70);
         on_len  = $urandom_range(1, 6);
         off_len = $urandom_range(1, 6);
         for (int i = 0; i < stretch; i++) begin
            @(negedge clock);
            case (style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < pct);
               default: rsp_stall <= ((i % (on_len + off_len)) < on_len);
            endcase
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [2:0] pick_offset();
      case ($urandom_range(0, 9))
         0:       return 3'd0;
         1:       return 3'd7;
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   // call right after a falling edge; returns right after a falling edge
   task automatic push_byte(input logic [7:0] first, input logic [7:0] next,
                            input logic [7:0] old);
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      req_valid          <= 1'b1;
      req_src_byte_first <= first;
      req_src_byte_next  <= next;
      req_dst_byte_old   <= old;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(50, 150);
            gap_left   = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 6);
         end
      end
   endtask

   // setup then access phase; psel stays high so writes can run back to back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   // hold the stream until every result is back, then reprogram
   task automatic set_blit(input logic [2:0] d_off, input logic [2:0] s_off,
                           input logic [11:0] width, input logic [2:0] mode);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_write(REG_DEST_OFF, 32'(d_off));
      csr_write(REG_SRC_OFF, 32'(s_off));
      csr_write(REG_ROW_W, 32'(width));
      csr_write(REG_MODE, 32'(mode));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [2:0]  mode_list[8];
      logic [2:0]  d_off, s_off, mode;
      logic [11:0] width;
      int          sent, count, nbytes, r;
      mode_list = '{MODE_COPY, MODE_OR, MODE_AND, MODE_ANDNOT, MODE_XOR,
                    MODE_XOR + 3'd1, MODE_XOR + 3'd2, MODE_XOR + 3'd3};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_src_byte_first = 8'h00;
      req_src_byte_next  = 8'h00;
      req_dst_byte_old   = 8'h00;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = 4'h0;
      csr_pwdata         = 32'h0;
      burst_left         = 1;
      gap_left           = 0;
      sent               = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every combine mode, all offsets, an empty row, extreme bytes
      for (int m = 0; m < 8; m++) begin
         width = (mode_list[m] == MODE_AND) ? 12'd0 : 12'(3 * m + 2);
         set_blit(3'(m), 3'((m * 5) % 8), width, mode_list[m]);
         push_byte(8'hFF, 8'hFF, 8'h00);
         push_byte(8'h00, 8'h00, 8'hFF);
         push_byte(8'h55, 8'hAA, 8'hC3);
      end

      // random geometry; rows are often cut short so the counter runs past
      // the end of the next setting
      while (sent < NUM_ITEMS) begin
         d_off = pick_offset();
         s_off = pick_offset();
         r = $urandom_range(0, 59);
         case (r)
            0:       width = 12'd0;
            1:       width = 12'd1;
            2:       width = MAX_ROW_PIXELS;
            3:       width = 12'($urandom_range(65, 4094));
            default: width = 12'($urandom_range(1, 64));
         endcase
         if ($urandom_range(0, 9) < 8) begin
            mode = mode_list[$urandom_range(0, 4)];
         end else begin
            mode = MODE_XOR + 3'($urandom_range(1, 3));
         end
         set_blit(d_off, s_off, width, mode);
         nbytes = (int'(d_off) + int'(width) + 7) / 8;
         if (nbytes == 0) begin
            nbytes = 1;
         end
         count = nbytes * $urandom_range(1, 2) + $urandom_range(0, 2);
         if (count > 600) begin
            count = 600;
         end
         if (count > NUM_ITEMS - sent) begin
            count = NUM_ITEMS - sent;
         end
         repeat (count) begin
            push_byte(pick_byte(), pick_byte(), pick_byte());
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
